>>> sv/spmc_pkg.sv
`default_nettype none
package spmc_pkg;

  localparam int NumSignals = 64;
  localparam int SigIdxW    = $clog2(NumSignals);

  localparam logic [6:0] SigKill = 7'd9;
  localparam logic [6:0] SigStop = 7'd19;

  localparam logic [NumSignals-1:0] FixedMask =
    (NumSignals'(1) << (SigKill - 7'd1)) | (NumSignals'(1) << (SigStop - 7'd1));

  typedef enum logic [2:0] {
    REQ_SEND    = 3'd0,
    REQ_SETACT  = 3'd1,
    REQ_MASK    = 3'd2,
    REQ_QUERY   = 3'd3,
    REQ_DELIVER = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    HOW_BLOCK   = 2'd0,
    HOW_UNBLOCK = 2'd1,
    HOW_SET     = 2'd2,
    HOW_BAD     = 2'd3
  } how_e;

  typedef enum logic [1:0] {
    ACT_DEFAULT = 2'd0,
    ACT_HANDLER = 2'd1,
    ACT_IGNORE  = 2'd2,
    ACT_ERROR   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ERR  = 2'd1,
    STAT_NONE = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    EFF_NONE = 2'd0,
    EFF_TERM = 2'd1,
    EFF_STOP = 2'd2,
    EFF_CONT = 2'd3
  } eff_e;

  typedef enum logic [1:0] {
    CFG_REAL_UID = 2'd0,
    CFG_EFF_UID  = 2'd1,
    CFG_QACTIVE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [6:0]  signal_number;
    logic [1:0]  how;
    logic        has_set;
    logic [63:0] set_word;
    logic [1:0]  new_action;
    logic        has_sender;
    logic [31:0] sender_real_uid;
    logic [31:0] sender_effective_uid;
  } req_t;

  typedef struct packed {
    logic [31:0] tgt_ruid;
    logic [31:0] eff_uid;
    logic        queue_active;
  } cfg_t;

  typedef struct packed {
    stat_e       status;
    logic [6:0]  signal_out;
    logic        delivered_kind;
    eff_e        default_effect;
    act_e        old_action;
    logic [63:0] word_out;
  } rsp_t;

  function automatic eff_e default_effect_of(logic [6:0] sig);
    eff_e eff;
    eff = EFF_NONE;
    if (sig inside {[7'd1:7'd16], [7'd24:7'd27], 7'd31}) begin
      eff = EFF_TERM;
    end else if (sig inside {[7'd19:7'd22]}) begin
      eff = EFF_STOP;
    end else if (sig == 7'd18) begin
      eff = EFF_CONT;
    end
    return eff;
  endfunction

endpackage
`default_nettype wire

>>> sv/spmc_core.sv
`default_nettype none
module spmc_core import spmc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire req_t req_i,
  input  wire cfg_t cfg_i,
  output rsp_t      rsp_o
);

  logic [NumSignals-1:0] pend_q, pend_d;
  logic [NumSignals-1:0] blk_q, blk_d;
  logic [NumSignals-1:0] act_hi_q, act_hi_d;
  logic [NumSignals-1:0] act_lo_q, act_lo_d;

  logic [SigIdxW-1:0]    sig_idx;
  logic [NumSignals-1:0] sig_bit;
  act_e                  act_cur;
  logic                  perm_ok;
  logic                  sig_fixed;
  logic [NumSignals-1:0] set_masked;

  // deliver scan
  logic [NumSignals-1:0] cand;
  logic [NumSignals-1:0] live;
  logic [NumSignals-1:0] lowest;
  logic [NumSignals-1:0] upto;
  logic [SigIdxW-1:0]    dlv_idx;
  act_e                  dlv_act;
  logic [6:0]            dlv_sig;

  assign sig_idx    = SigIdxW'(req_i.signal_number - 7'd1);
  assign sig_bit    = NumSignals'(1) << sig_idx;
  assign act_cur    = act_e'({act_hi_q[sig_idx], act_lo_q[sig_idx]});
  assign sig_fixed  = (req_i.signal_number == SigKill) || (req_i.signal_number == SigStop);
  assign set_masked = req_i.set_word[NumSignals-1:0];

  assign perm_ok = (req_i.sender_real_uid == 32'd0) || (req_i.sender_effective_uid == 32'd0) ||
                   (req_i.sender_real_uid == cfg_i.tgt_ruid) ||
                   (req_i.sender_real_uid == cfg_i.eff_uid) ||
                   (req_i.sender_effective_uid == cfg_i.tgt_ruid) ||
                   (req_i.sender_effective_uid == cfg_i.eff_uid);

  assign cand   = pend_q & ~blk_q;
  assign live   = cand & ~(act_hi_q & ~act_lo_q);
  assign lowest = live & (~live + NumSignals'(1));
  // lowest live bit and everything below; all ones when none is live
  assign upto   = live ^ (live - NumSignals'(1));

  always_comb begin
    dlv_idx = '0;
    for (int i = 0; i < NumSignals; i++) begin
      if (lowest[i]) begin
        dlv_idx = dlv_idx | SigIdxW'(i);
      end
    end
  end

  assign dlv_act = act_e'({act_hi_q[dlv_idx], act_lo_q[dlv_idx]});
  assign dlv_sig = 7'(dlv_idx) + 7'd1;

  always_comb begin
    pend_d   = pend_q;
    blk_d    = blk_q;
    act_hi_d = act_hi_q;
    act_lo_d = act_lo_q;
    rsp_o.status         = STAT_OK;
    rsp_o.signal_out     = 7'd0;
    rsp_o.delivered_kind = 1'b0;
    rsp_o.default_effect = EFF_NONE;
    rsp_o.old_action     = ACT_DEFAULT;
    rsp_o.word_out       = 64'd0;
    if (en_i) begin
      case (req_e'(req_i.req_type))
        REQ_SEND: begin
          if (req_i.signal_number > 7'(NumSignals)) begin
            rsp_o.status = STAT_ERR;
          end else if (req_i.has_sender && !perm_ok) begin
            rsp_o.status = STAT_ERR;
          end else if (req_i.signal_number != 7'd0) begin
            if (sig_fixed || act_cur != ACT_IGNORE) begin
              pend_d = pend_q | sig_bit;
            end
          end
        end
        REQ_SETACT: begin
          if (req_i.signal_number == 7'd0 || req_i.signal_number > 7'(NumSignals) ||
              sig_fixed) begin
            rsp_o.status = STAT_ERR;
          end else begin
            rsp_o.old_action  = act_cur;
            act_hi_d[sig_idx] = req_i.new_action[1];
            act_lo_d[sig_idx] = req_i.new_action[0];
            if (act_e'(req_i.new_action) == ACT_IGNORE) begin
              pend_d = pend_q & ~sig_bit;
            end
          end
        end
        REQ_MASK: begin
          rsp_o.word_out = 64'(blk_q);
          if (req_i.has_set) begin
            case (how_e'(req_i.how))
              HOW_BLOCK:   blk_d = blk_q | set_masked;
              HOW_UNBLOCK: blk_d = blk_q & ~set_masked;
              HOW_SET:     blk_d = set_masked;
              default:     rsp_o.status = STAT_ERR;
            endcase
          end
          blk_d = blk_d & ~FixedMask;
        end
        REQ_QUERY: begin
          rsp_o.word_out = 64'(pend_q);
        end
        REQ_DELIVER: begin
          rsp_o.status = STAT_NONE;
          if (cfg_i.queue_active) begin
            pend_d = pend_q & ~(cand & upto);
            if (live != '0) begin
              rsp_o.signal_out = dlv_sig;
              case (dlv_act)
                ACT_ERROR: rsp_o.status = STAT_ERR;
                ACT_DEFAULT: begin
                  rsp_o.status         = STAT_OK;
                  rsp_o.default_effect = default_effect_of(dlv_sig);
                end
                default: begin
                  rsp_o.status         = STAT_OK;
                  rsp_o.delivered_kind = 1'b1;
                end
              endcase
            end
          end
        end
        default: begin
          rsp_o.status = STAT_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      blk_q    <= '0;
      act_hi_q <= '0;
      act_lo_q <= '0;
    end else begin
      pend_q   <= pend_d;
      blk_q    <= blk_d;
      act_hi_q <= act_hi_d;
      act_lo_q <= act_lo_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/signal_pending_mask_controller.sv
// Signal pending/mask controller.
// Request channel: a request word is taken at a rising edge with start high
// and busy low. busy is held low, so one request can be issued every cycle.
// The request is registered, then worked against the pending, blocked and
// disposition state in the next cycle, which also updates that state.
// Result channel: done_o rises at the edge after the request edge and stays
// high for one cycle with the result ports valid. Throughput is one request
// per cycle. The receiver cannot stall, so every result is taken at the edge
// that ends its done_o cycle.
// Configuration channel: cfg_valid_i with cfg_ready_o (always high) writes
// cfg_data_i to the register at cfg_index_i: 0 target real uid, 1 target
// effective uid, 2 queue active. Writes take effect at once for the next
// request; write only while no request is in flight.
// Reset (rst_ni low, asynchronous) clears the pending and blocked sets, sets
// every disposition to default, zeroes the configuration registers and drops
// any request in flight.
`default_nettype none
module signal_pending_mask_controller import spmc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [6:0]  signal_number_i,
  input  wire logic [1:0]  how_i,
  input  wire logic        has_set_i,
  input  wire logic [63:0] set_word_i,
  input  wire logic [1:0]  new_action_i,
  input  wire logic        has_sender_i,
  input  wire logic [31:0] sender_real_uid_i,
  input  wire logic [31:0] sender_effective_uid_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [6:0]       signal_out_o,
  output logic             delivered_kind_o,
  output logic [1:0]       default_effect_o,
  output logic [1:0]       old_action_o,
  output logic [63:0]      word_out_o
);

  logic in_valid_q;
  req_t req_q;
  cfg_t cfg_q;
  logic done_q;
  rsp_t rsp_d, rsp_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q.req_type             <= req_type_i;
    req_q.signal_number        <= signal_number_i;
    req_q.how                  <= how_i;
    req_q.has_set              <= has_set_i;
    req_q.set_word             <= set_word_i;
    req_q.new_action           <= new_action_i;
    req_q.has_sender           <= has_sender_i;
    req_q.sender_real_uid      <= sender_real_uid_i;
    req_q.sender_effective_uid <= sender_effective_uid_i;
    rsp_q                      <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_REAL_UID: cfg_q.tgt_ruid     <= cfg_data_i;
        CFG_EFF_UID:  cfg_q.eff_uid      <= cfg_data_i;
        CFG_QACTIVE:  cfg_q.queue_active <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  spmc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_valid_q),
    .req_i  (req_q),
    .cfg_i  (cfg_q),
    .rsp_o  (rsp_d)
  );

  assign done_o           = done_q;
  assign status_o         = rsp_q.status;
  assign signal_out_o     = rsp_q.signal_out;
  assign delivered_kind_o = rsp_q.delivered_kind;
  assign default_effect_o = rsp_q.default_effect;
  assign old_action_o     = rsp_q.old_action;
  assign word_out_o       = rsp_q.word_out;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("result strobe missing two cycles after request");

  a_empty_no_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_NONE) |-> (signal_out_o == 7'd0 && word_out_o == 64'd0))
    else $error("empty deliver reports a signal");

  a_handler_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && delivered_kind_o) |->
      (status_o == STAT_OK && default_effect_o == EFF_NONE && signal_out_o != 7'd0))
    else $error("handler delivery with bad status or effect");

endmodule
`default_nettype wire
